FILE: src/pgg_pkg.sv
// -----------------------------------------------------------------------------
// pgg_pkg
// Shared types, constants and coefficient functions for the pixel gamma and
// gain transform.
// -----------------------------------------------------------------------------
package pgg_pkg;

   localparam int DIM_W      = 13;
   localparam int CNT_W      = 24;
   localparam int ITER_N     = 24;
   localparam int MAX_DIM_DEF = 4096;

   localparam logic [7:0] CSR_GAIN  = 8'd0;
   localparam logic [7:0] CSR_GAMMA = 8'd1;
   localparam logic [7:0] CSR_ROWS  = 8'd2;
   localparam logic [7:0] CSR_COLS  = 8'd3;

   typedef struct packed {
      logic [7:0] pixel_in;
      logic       keep_in;
      logic       strobe_in;
      logic       user_in;
      logic       last_in;
      logic       stream_id_in;
      logic       dest_in;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_out;
      logic       keep_out;
      logic       strobe_out;
      logic       user_out;
      logic       last_out;
      logic       stream_id_out;
      logic       dest_out;
      logic       frame_end;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOG, ST_EXPO, ST_POW, ST_SHIFT, ST_GAIN, ST_SCALE, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic log_step;
      logic expo;
      logic pow_step;
      logic shift;
      logic gain;
      logic scale;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_step;
      logic out_free;
   } status_type;

   typedef logic [ITER_N:0][31:0] coef_table_type;

   // integer square root, evaluated at elaboration only
   function automatic logic [63:0] isqrt64(logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v    = v_in;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int s = 0; s < 32; s++) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // 2^-(2^-i) factors in Q31, entry i for i = 1..24
   function automatic coef_table_type exp_coef_table();
      coef_table_type t;
      logic [63:0]    c;
      t = '0;
      c = 64'd1 << 30;
      for (int i = 1; i <= ITER_N; i++) begin
         c    = isqrt64(c << 31);
         t[i] = c[31:0];
      end
      return t;
   endfunction

endpackage

FILE: src/pixel_gamma_gain_transform.sv
// -----------------------------------------------------------------------------
// pixel_gamma_gain_transform
// Gamma and gain correction of an 8-bit gray pixel stream with sidebands.
// -----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready carry one pixel and its sideband bits per transfer.
//   rsp_valid/rsp_ready return one corrected pixel per input, in order, with
//   the sidebands copied and frame_end set on the last pixel of a frame.
//   csr_valid/csr_ready write gain (0), gamma exponent (1), rows (2) and
//   columns (3); csr_ready is always high. Write registers only while idle.
// Processing:
//   One pixel is in work at a time. From the input transfer to the result
//   in the output register it passes 24 log2 squaring steps, an exponent
//   step and 24 exp2 product steps on 32x32 multipliers, then shift, gain,
//   scale and output load steps. The next pixel is taken only once the
//   sequencer is back in idle.
// Reset:
//   Synchronous; gain and gamma return to 1.0, frame size to 1x1 and the
//   pixel counter to zero.
// Stall:
//   The finished result holds in the output register while rsp_ready is low;
//   a new pixel is still accepted and runs until its result needs the slot.
// -----------------------------------------------------------------------------
module pixel_gamma_gain_transform
   import pgg_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   pgg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pgg_dpath #(
      .MAX_DIM (MAX_DIM)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/pgg_ctrl.sv
// -----------------------------------------------------------------------------
// pgg_ctrl
// Sequencer for one pixel: log2 iterations, exponent scale, exp2 iterations,
// shift, gain, output scale and output register load.
// -----------------------------------------------------------------------------
module pgg_ctrl
   import pgg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_LOG;
         ST_LOG:   if (status.last_step) state_in = ST_EXPO;
         ST_EXPO:  state_in = ST_POW;
         ST_POW:   if (status.last_step) state_in = ST_SHIFT;
         ST_SHIFT: state_in = ST_GAIN;
         ST_GAIN:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_OUT;
         ST_OUT:   if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_LOG:   cmd.log_step = 1'b1;
         ST_EXPO:  cmd.expo     = 1'b1;
         ST_POW:   cmd.pow_step = 1'b1;
         ST_SHIFT: cmd.shift    = 1'b1;
         ST_GAIN:  cmd.gain     = 1'b1;
         ST_SCALE: cmd.scale    = 1'b1;
         ST_OUT:   cmd.out_load = status.out_free;
         default:  cmd          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/pgg_dpath.sv
// -----------------------------------------------------------------------------
// pgg_dpath
// Registers, the 32x32 multiplier steps, frame counter and output
// register of the gamma and gain transform.
// -----------------------------------------------------------------------------
module pgg_dpath
   import pgg_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  req_type          req_data,
   input  logic             csr_valid,
   input  logic [7:0]       csr_index,
   input  logic [15:0]      csr_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   localparam coef_table_type EXP_COEF = exp_coef_table();

   // configuration
   logic [15:0]      gain_ff;
   logic [15:0]      gamma_ff;
   logic [DIM_W-1:0] rows_ff;
   logic [DIM_W-1:0] cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= 16'd256;
         gamma_ff <= 16'd256;
         rows_ff  <= DIM_W'(1);
         cols_ff  <= DIM_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN:  gain_ff  <= csr_data;
            CSR_GAMMA: gamma_ff <= csr_data;
            CSR_ROWS:  rows_ff  <= csr_data[DIM_W-1:0];
            CSR_COLS:  cols_ff  <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp frame dimensions
   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] d);
      if (d == '0) return DIM_W'(1);
      if (int'(d) > MAX_DIM) return DIM_W'(MAX_DIM);
      return d;
   endfunction

   logic [2*DIM_W-1:0] packet;
   logic [CNT_W:0]     next_cnt;
   logic               frame_end;
   logic [CNT_W-1:0]   pix_cnt_ff;

   assign packet    = clamp_dim(rows_ff) * clamp_dim(cols_ff);
   assign next_cnt  = {1'b0, pix_cnt_ff} + (CNT_W+1)'(1);
   assign frame_end = ({1'b0, next_cnt} >= (CNT_W+2)'(packet)) || next_cnt[CNT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_cnt_ff <= '0;
      end else if (cmd.load) begin
         pix_cnt_ff <= frame_end ? '0 : next_cnt[CNT_W-1:0];
      end
   end

   // leading one of the pixel
   logic [2:0] lead;
   always_comb begin
      lead = 3'd0;
      for (int b = 1; b < 8; b++) begin
         if (req_data.pixel_in[b]) lead = 3'(b);
      end
   end

   // iteration counter
   logic [4:0] step_ff;
   assign status.last_step = (step_ff == 5'(ITER_N - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.load || cmd.expo || status.last_step) begin
         step_ff <= '0;
      end else if (cmd.log_step || cmd.pow_step) begin
         step_ff <= step_ff + 5'd1;
      end
   end

   // datapath registers
   req_type      item_ff;
   logic         end_ff;
   logic [2:0]   lead_ff;
   logic [31:0]  m_ff;
   logic [23:0]  frac_ff;
   logic [34:0]  e_ff;
   logic [31:0]  r_ff;
   logic [8:0]   p_ff;
   logic [16:0]  q_ff;
   logic [7:0]   y_ff;

   logic [63:0]  sq_prod;
   logic [63:0]  r_prod;
   logic [27:0]  log_neg;
   logic [42:0]  e_prod;
   logic [34:0]  e_scaled;
   logic [10:0]  k_val;
   logic [4:0]   coef_idx;
   logic [4:0]   shamt;
   logic [24:0]  q_prod;
   logic [24:0]  y_prod;
   logic [16:0]  y_full;

   assign sq_prod  = 64'(m_ff) * 64'(m_ff);
   assign coef_idx = step_ff + 5'd1;
   assign r_prod   = 64'(r_ff) * 64'(EXP_COEF[coef_idx]);
   assign log_neg  = 28'(8 << 24) - {1'b0, lead_ff, frac_ff};
   assign e_prod   = 43'(log_neg) * 43'(gamma_ff);
   assign e_scaled = e_prod[42:8];
   assign k_val    = e_ff[34:24];
   assign shamt    = 5'd23 + 5'(k_val[3:0]);
   assign q_prod   = 25'(p_ff) * 25'(gain_ff);
   assign y_prod   = 25'(q_ff) * 25'd255;
   assign y_full   = y_prod[24:8];

   always_ff @(posedge clock) begin
      // capture pixel and normalize mantissa into Q31
      if (cmd.load) begin
         item_ff <= req_data;
         end_ff  <= frame_end;
         lead_ff <= lead;
         m_ff    <= 32'(req_data.pixel_in) << (5'd31 - 5'(lead));
         frac_ff <= '0;
      end
      // square and renormalize, one log2 bit per step
      if (cmd.log_step) begin
         if (sq_prod[63]) begin
            m_ff    <= sq_prod[63:32];
            frac_ff <= {frac_ff[22:0], 1'b1};
         end else begin
            m_ff    <= sq_prod[62:31];
            frac_ff <= {frac_ff[22:0], 1'b0};
         end
      end
      // scale log by exponent, bias down
      if (cmd.expo) begin
         e_ff <= (e_scaled > 35'd4) ? e_scaled - 35'd4 : '0;
         r_ff <= 32'd1 << 31;
      end
      // apply one fractional exp2 factor per step
      if (cmd.pow_step && e_ff[5'd23 - step_ff]) begin
         r_ff <= r_prod[62:31];
      end
      // integer part of exponent, special cases
      if (cmd.shift) begin
         if (item_ff.pixel_in == 8'd0) begin
            p_ff <= (gamma_ff == 16'd0) ? 9'd256 : 9'd0;
         end else if (k_val > 11'd8) begin
            p_ff <= 9'd0;
         end else begin
            p_ff <= 9'(r_ff >> shamt);
         end
      end
      if (cmd.gain) begin
         q_ff <= q_prod[24:8];
      end
      // scale to 255 and saturate
      if (cmd.scale) begin
         y_ff <= (y_full > 17'd255) ? 8'd255 : y_full[7:0];
      end
   end

   // output register
   logic    out_valid_ff;
   rsp_type out_ff;

   assign status.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_data        = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.pixel_out     <= y_ff;
         out_ff.keep_out      <= item_ff.keep_in;
         out_ff.strobe_out    <= item_ff.strobe_in;
         out_ff.user_out      <= item_ff.user_in;
         out_ff.last_out      <= item_ff.last_in;
         out_ff.stream_id_out <= item_ff.stream_id_in;
         out_ff.dest_out      <= item_ff.dest_in;
         out_ff.frame_end     <= end_ff;
      end
   end

endmodule
